// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fbfl_pkg.sv -----
package fbfl_pkg;

	localparam int IDX_W = 9;
	localparam int OPC_W = 2;
	localparam int STAT_W = 2;
	localparam int CNT_W = 9;

	localparam int TDATA_IN_W = 16;
	localparam int TUSER_W = 2;
	localparam int TDATA_OUT_W = 24;

	localparam int DEF_MAX_BLOCKS = 256;
	localparam logic [CNT_W-1:0] RESET_BLOCK_COUNT = 9'd256;

	localparam logic [OPC_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OPC_W-1:0] OP_FREE = 2'd1;
	localparam logic [OPC_W-1:0] OP_INIT = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_ALLOC,
		K_FREE,
		K_INIT,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ALLOC_RD,
		BK_SWEEP
	} back_state_t;

endpackage

// ----- hw/rtl/fixed_block_free_list_allocator_top.sv -----
// Fixed-size block allocator over a linked free list of block indices 1..pool size.
// Command stream (s_axis): tuser carries the opcode (alloc, free, reinit), tdata
// the block index to free. One result per command leaves on m_axis: granted
// index, status and the free count after the command.
// cfg_we/cfg_wdata load the pool size used by the next reinit.
// Commands enter a two-entry queue, so up to two are taken while the list engine
// is busy or the result register is full; a stalled receiver holds the result register
// and the engine stops once it has a result to load, while the queue keeps filling.
// Per command in the engine: free and no-op load their result as they are dequeued,
// alloc first reads the head's link from the link RAM before the head can move, and
// reinit is dequeued, then writes every link RAM entry, the whole depth, not only the pool.
// Results are registered: a command passes the queue, the engine, then the result register.
// Reset: the engine runs the same chaining pass over the link RAM with a pool of
// 256 blocks (or MAX_BLOCKS if lower) and produces no result for it; commands
// accepted meanwhile wait in the queue.
module fixed_block_free_list_allocator_top #(
	parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [fbfl_pkg::TDATA_IN_W-1:0]   s_axis_tdata,  // [8:0] block_index
	input  logic [fbfl_pkg::TUSER_W-1:0]      s_axis_tuser,  // [1:0] opcode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [8:0] granted_index, [10:9] status, [19:11] free_count
	output logic [fbfl_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [fbfl_pkg::CNT_W-1:0]        cfg_wdata
);
	import fbfl_pkg::*;

	logic [CNT_W-1:0]  block_count_q;
	logic              q_push;
	logic              q_ready;
	cmd_t              push_cmd;
	logic              q_pop;
	logic              q_valid;
	cmd_t              pop_cmd;
	logic [IDX_W-1:0]  granted_index;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  free_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= RESET_BLOCK_COUNT;
		end else if (cfg_we) begin
			block_count_q <= cfg_wdata;
		end
	end

	fbfl_front u_front (
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.opcode      (s_axis_tuser[OPC_W-1:0]),
		.block_index (s_axis_tdata[IDX_W-1:0]),
		.q_push      (q_push),
		.q_ready     (q_ready),
		.q_cmd       (push_cmd)
	);

	fbfl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_cmd   (push_cmd),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_cmd    (pop_cmd)
	);

	fbfl_back #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.block_count   (block_count_q),
		.q_valid       (q_valid),
		.q_cmd         (pop_cmd),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.granted_index (granted_index),
		.status        (status),
		.free_count    (free_count)
	);

	assign m_axis_tdata = {{(TDATA_OUT_W - IDX_W - STAT_W - CNT_W){1'b0}},
		free_count, status, granted_index};

endmodule

// ----- hw/rtl/fbfl_ram.sv -----
module fbfl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/fbfl_front.sv -----
module fbfl_front (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fbfl_pkg::OPC_W-1:0]  opcode,
	input  logic [fbfl_pkg::IDX_W-1:0]  block_index,
	output logic                        q_push,
	input  logic                        q_ready,
	output fbfl_pkg::cmd_t              q_cmd
);
	import fbfl_pkg::*;

	assign in_ready = q_ready;
	assign q_push = in_valid && q_ready;

	// A free of the null index never touches the list, so it goes down as a no-op.
	always_comb begin
		q_cmd.idx = block_index;
		case (opcode)
			OP_ALLOC: q_cmd.kind = K_ALLOC;
			OP_FREE:  q_cmd.kind = (block_index == '0) ? K_NOP : K_FREE;
			OP_INIT:  q_cmd.kind = K_INIT;
			default:  q_cmd.kind = K_NOP;
		endcase
	end

endmodule

// ----- hw/rtl/fbfl_queue.sv -----
module fbfl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  fbfl_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           pop_valid,
	output fbfl_pkg::cmd_t pop_cmd
);
	import fbfl_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- hw/rtl/fbfl_back.sv -----
module fbfl_back #(
	parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [fbfl_pkg::CNT_W-1:0]   block_count,
	input  logic                         q_valid,
	input  fbfl_pkg::cmd_t               q_cmd,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fbfl_pkg::IDX_W-1:0]   granted_index,
	output logic [fbfl_pkg::STAT_W-1:0]  status,
	output logic [fbfl_pkg::CNT_W-1:0]   free_count
);
	import fbfl_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = (32'(c) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : c;
		return r;
	endfunction

	back_state_t state_q, state_d;
	logic [AW-1:0]    sweep_q, sweep_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] pool_q, pool_d;
	logic [CNT_W-1:0] init_n_q, init_n_d;
	logic             reply_q, reply_d;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_granted_q;
	status_t          out_status_q;
	logic [CNT_W-1:0] out_count_q;

	logic             out_free;
	logic             out_load;
	logic [IDX_W-1:0] load_granted;
	status_t          load_status;
	logic [CNT_W-1:0] load_count;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [IDX_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [IDX_W-1:0] mem_rdata;

	logic [31:0]      entry_no;
	logic             sweep_last;

	// Entry i of the list lives at address i-1.
	fbfl_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_free = !out_valid_q || out_ready;
	assign entry_no = 32'(sweep_q) + 32'd1;
	assign sweep_last = (sweep_q == AW'(MAX_BLOCKS - 1));

	always_comb begin
		state_d = state_q;
		sweep_d = sweep_q;
		head_d = head_q;
		count_d = count_q;
		pool_d = pool_q;
		init_n_d = init_n_q;
		reply_d = reply_q;
		q_pop = 1'b0;
		mem_we = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = AW'(head_q - IDX_W'(1));
		out_load = 1'b0;
		load_granted = '0;
		load_status = ST_OK;
		load_count = count_q;

		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					case (q_cmd.kind)
						K_ALLOC: begin
							if (head_q == '0 || 32'(head_q) > MAX_BLOCKS) begin
								if (out_free) begin
									q_pop = 1'b1;
									out_load = 1'b1;
									load_status = ST_EMPTY;
								end
							end else begin
								// fetch the link of the head; the alloc finishes in BK_ALLOC_RD once the result register is free
								q_pop = 1'b1;
								mem_re = 1'b1;
								state_d = BK_ALLOC_RD;
							end
						end
						K_FREE: begin
							if (out_free) begin
								q_pop = 1'b1;
								out_load = 1'b1;
								if (q_cmd.idx > pool_q) begin
									load_status = ST_RANGE;
								end else begin
									mem_we = 1'b1;
									mem_waddr = AW'(q_cmd.idx - IDX_W'(1));
									mem_wdata = head_q;
									head_d = q_cmd.idx;
									if (count_q < pool_q) begin
										count_d = count_q + CNT_W'(1);
									end
									load_count = count_d;
								end
							end
						end
						K_INIT: begin
							q_pop = 1'b1;
							init_n_d = clamp_count(block_count);
							sweep_d = '0;
							reply_d = 1'b1;
							state_d = BK_SWEEP;
						end
						default: begin
							if (out_free) begin
								q_pop = 1'b1;
								out_load = 1'b1;
							end
						end
					endcase
				end
			end
			BK_ALLOC_RD: begin
				if (out_free) begin
					head_d = mem_rdata;
					if (count_q != '0) begin
						count_d = count_q - CNT_W'(1);
					end
					out_load = 1'b1;
					load_granted = head_q;
					load_count = count_d;
					state_d = BK_IDLE;
				end
			end
			BK_SWEEP: begin
				mem_we = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = (entry_no < 32'(init_n_q)) ? IDX_W'(entry_no + 32'd1) : '0;
				if (!sweep_last) begin
					sweep_d = sweep_q + AW'(1);
				end else if (!reply_q || out_free) begin
					pool_d = init_n_q;
					head_d = (init_n_q != '0) ? IDX_W'(1) : '0;
					count_d = init_n_q;
					out_load = reply_q;
					load_count = init_n_q;
					reply_d = 1'b0;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_SWEEP;
			sweep_q <= '0;
			head_q <= '0;
			count_q <= '0;
			pool_q <= '0;
			init_n_q <= clamp_count(RESET_BLOCK_COUNT);
			reply_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			head_q <= head_d;
			count_q <= count_d;
			pool_q <= pool_d;
			init_n_q <= init_n_d;
			reply_q <= reply_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_granted_q <= load_granted;
			out_status_q <= load_status;
			out_count_q <= load_count;
		end
	end

	assign out_valid = out_valid_q;
	assign granted_index = out_granted_q;
	assign status = out_status_q;
	assign free_count = out_count_q;

endmodule

// ----- hw/rtl/fbfl_checker.sv -----
`include "assert_macros.svh"

module fbfl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [fbfl_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
	import fbfl_pkg::*;

	logic [IDX_W-1:0]  granted;
	logic [STAT_W-1:0] stat;
	logic [CNT_W-1:0]  cnt;

	assign granted = m_axis_tdata[IDX_W-1:0];
	assign stat = m_axis_tdata[IDX_W+STAT_W-1:IDX_W];
	assign cnt = m_axis_tdata[IDX_W+STAT_W+CNT_W-1:IDX_W+STAT_W];

	`ASSERT_NEXT(a_result_held, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	`ASSERT_IMPL(a_status_legal, clk, arst_n, m_axis_tvalid, stat == ST_OK || stat == ST_EMPTY || stat == ST_RANGE, "undefined status code")

	`ASSERT_IMPL(a_grant_ok, clk, arst_n, m_axis_tvalid && granted != '0, stat == ST_OK, "block granted with error status")

	// an empty list implies the free counter has already reached zero
	`ASSERT_IMPL(a_empty_zero, clk, arst_n, m_axis_tvalid && stat == ST_EMPTY, granted == '0 && cnt == '0, "empty pool reported with blocks")

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_fbfl_checker (.*);
